// ----- src/bffa_pkg.sv -----
// Package for the bitmap first-fit unit allocator.
// Holds field widths, parameter defaults and status/action codes.
// No dependencies.
package bffa_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 17;
    localparam int STATUS_W = 2;
    localparam int MAP_W    = 8;

    // Parameter defaults
    localparam int UNIT_BYTES_DEF = 64;
    localparam int NUM_UNITS_DEF  = 1024;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_BLOCK = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd3;

    // Action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

// ----- src/bffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/bffa_cdiv.sv -----
// Divide by the unit size for the bitmap first-fit allocator; quotient and done are registered.
// Depends on bffa_pkg for the default dividend width; the divisor must be a power of two.
module bffa_cdiv
    import bffa_pkg::*;
#(
    parameter int DIVISOR = UNIT_BYTES_DEF,
    parameter int WIDTH   = ADDR_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    // Unit size is a power of two, so the quotient is a right shift
    localparam int SHIFT = $clog2(DIVISOR);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic             done_reg, done_next;

    // Capture the shifted dividend on start
    always_comb
    begin
        quo_next  = quo_reg;
        done_next = start;
        if (start)
        begin
            quo_next = dividend >> SHIFT;
        end
    end

    // Done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/bitmap_first_fit_unit_allocator.sv -----
// Top level of the bitmap first-fit unit allocator: sequencer around the used-bit map.
// Depends on bffa_pkg, bffa_ram (used-bit map) and bffa_cdiv (divide by unit size).
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_data (block_base)
//  in        in         in_valid/in_stall    action, size_bytes, address
//  out       out        out_valid/out_stall  status, address_out, block_empty
//
//  Reset runs a clearing pass over all ceil(NUM_UNITS/8) map words, in_stall held high.
//  UNIT_BYTES is a power of two, so each divide by the unit size is a registered shift.
//  Zero size goes straight to the response; a range error or an oversized allocate ends
//  after the check; a free reads, then writes each cleared word; an allocate scans map words
//  up to and including the fit, then reads, then writes each marked word.
//  One transaction in flight; a finished result waits in the output register under out_stall
//  while the next transaction is accepted.
module bitmap_first_fit_unit_allocator
    import bffa_pkg::*;
#(
    parameter int UNIT_BYTES = UNIT_BYTES_DEF,
    parameter int NUM_UNITS  = NUM_UNITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data,
    // request
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [SIZE_W-1:0]   size_bytes,
    input  logic [ADDR_W-1:0]   address,
    // result
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   address_out,
    output logic                block_empty
);

    localparam int DEPTH     = (NUM_UNITS + MAP_W - 1) / MAP_W;
    localparam int WORD_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UIDX_W    = WORD_W + 3;
    localparam int CNT_W     = $clog2(NUM_UNITS + 1);
    localparam int MAX_UNITS = ((1 << SIZE_W) - 1 + UNIT_BYTES - 1) / UNIT_BYTES;
    localparam int UNITS_W   = $clog2(MAX_UNITS + 1);
    localparam int CMP_W     = ((UNITS_W > CNT_W) ? UNITS_W : CNT_W) + 1;
    localparam int OFF_W     = ADDR_W + 2;
    localparam int SPAN      = NUM_UNITS * UNIT_BYTES;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(DEPTH - 1);

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_DIV_UNITS = 9'b000000100,
        S_CHECK     = 9'b000001000,
        S_SCAN      = 9'b000010000,
        S_DIV_FIRST = 9'b000100000,
        S_MARK_RD   = 9'b001000000,
        S_MARK_WR   = 9'b010000000,
        S_RESP      = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [CNT_W-1:0]      run_reg, run_next;
    logic [CNT_W-1:0]      start_reg, start_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      used_count_reg, used_count_next;
    logic [UNITS_W-1:0]    units_reg, units_next;
    logic                  action_reg, action_next;
    logic [ADDR_W-1:0]     addr_in_reg, addr_in_next;
    logic [ADDR_W-1:0]     base_reg;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ADDR_W-1:0]     address_out_reg, address_out_next;
    logic                  block_empty_reg, block_empty_next;

    logic                  ram_we, ram_re;
    logic [WORD_W-1:0]     ram_waddr, ram_raddr;
    logic [MAP_W-1:0]      ram_wdata, ram_rdata;
    logic                  cdiv_start, cdiv_done;
    logic [ADDR_W-1:0]     cdiv_dividend, cdiv_quotient;

    logic [ADDR_W:0]       off_ext;
    logic [OFF_W-1:0]      end_off;
    logic                  out_of_block;
    logic                  units_big;
    logic [MAP_W-1:0]      mark_mask;
    logic [WORD_W-1:0]     mark_last;
    logic [ADDR_W-1:0]     alloc_addr;

    function automatic logic [3:0] pop8(input logic [MAP_W-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < MAP_W; k++)
        begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    // Used-bit map, one bit per unit, eight units per word
    bffa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (DEPTH),
        .AW    (WORD_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Divide by the unit size: unit count and first unit of a free
    bffa_cdiv #(
        .DIVISOR (UNIT_BYTES),
        .WIDTH   (ADDR_W)
    ) u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cdiv_start),
        .dividend (cdiv_dividend),
        .done     (cdiv_done),
        .quotient (cdiv_quotient)
    );

    // Range checks
    assign off_ext      = {1'b0, addr_in_reg} - {1'b0, base_reg};
    assign end_off      = OFF_W'(off_ext[ADDR_W-1:0])
                        + OFF_W'(units_reg) * OFF_W'(UNIT_BYTES);
    assign out_of_block = off_ext[ADDR_W] || (end_off > OFF_W'(SPAN));
    assign units_big    = (CMP_W'(units_reg) > CMP_W'(NUM_UNITS));

    // Bits of the current word that fall inside [lo, hi)
    always_comb
    begin
        logic [UIDX_W:0] u_m;
        for (int j = 0; j < MAP_W; j++)
        begin
            u_m = {1'b0, word_reg, 3'(j)};
            mark_mask[j] = (u_m >= (UIDX_W+1)'(lo_reg)) && (u_m < (UIDX_W+1)'(hi_reg));
        end
    end

    assign mark_last  = WORD_W'((hi_reg - CNT_W'(1)) >> 3);
    assign alloc_addr = base_reg + ADDR_W'(lo_reg) * ADDR_W'(UNIT_BYTES);

    // Sequencer
    always_comb
    begin
        logic [CNT_W-1:0] run_v;
        logic [CNT_W-1:0] start_v;
        logic             found_v;
        logic [UIDX_W:0]  u_v;

        state_next       = state_reg;
        word_next        = word_reg;
        run_next         = run_reg;
        start_next       = start_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        used_count_next  = used_count_reg;
        units_next       = units_reg;
        action_next      = action_reg;
        addr_in_next     = addr_in_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        address_out_next = address_out_reg;
        block_empty_next = block_empty_reg;
        ram_we           = 1'b0;
        ram_waddr        = word_reg;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = word_reg;
        cdiv_start       = 1'b0;
        cdiv_dividend    = '0;

        // Walk the eight bits of the word on the read port, first fit wins
        run_v   = run_reg;
        start_v = start_reg;
        found_v = 1'b0;
        for (int i = 0; i < MAP_W; i++)
        begin
            u_v = {1'b0, word_reg, 3'(i)};
            if (!found_v && (u_v < (UIDX_W+1)'(NUM_UNITS)))
            begin
                if (ram_rdata[i])
                begin
                    run_v   = '0;
                    start_v = CNT_W'(u_v + (UIDX_W+1)'(1));
                end
                else
                begin
                    run_v = run_v + CNT_W'(1);
                    if (CMP_W'(run_v) >= CMP_W'(units_reg))
                    begin
                        found_v = 1'b1;
                    end
                end
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = word_reg;
                ram_wdata = '0;
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WORD_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next  = action;
                    addr_in_next = address;
                    if (size_bytes == '0)
                    begin
                        res_status_next = ST_ZERO_SIZE;
                        res_addr_next   = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cdiv_start    = 1'b1;
                        cdiv_dividend = ADDR_W'(size_bytes) + ADDR_W'(UNIT_BYTES - 1);
                        state_next    = S_DIV_UNITS;
                    end
                end
            end

            S_DIV_UNITS:
            begin
                if (cdiv_done)
                begin
                    units_next = cdiv_quotient[UNITS_W-1:0];
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (action_reg == ACT_ALLOC)
                begin
                    if (units_big)
                    begin
                        res_status_next = ST_NO_SPACE;
                        res_addr_next   = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        word_next  = '0;
                        run_next   = '0;
                        start_next = '0;
                        state_next = S_SCAN;
                    end
                end
                else if (out_of_block)
                begin
                    res_status_next = ST_OUT_BLOCK;
                    res_addr_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    cdiv_start    = 1'b1;
                    cdiv_dividend = off_ext[ADDR_W-1:0];
                    state_next    = S_DIV_FIRST;
                end
            end

            S_SCAN:
            begin
                if (found_v)
                begin
                    lo_next    = start_v;
                    hi_next    = start_v + CNT_W'(units_reg);
                    word_next  = WORD_W'(start_v >> 3);
                    state_next = S_MARK_RD;
                end
                else if (word_reg == LAST_WORD)
                begin
                    res_status_next = ST_NO_SPACE;
                    res_addr_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    // Fetch the next word while this one is evaluated
                    ram_re     = 1'b1;
                    ram_raddr  = word_reg + WORD_W'(1);
                    word_next  = word_reg + WORD_W'(1);
                    run_next   = run_v;
                    start_next = start_v;
                end
            end

            S_DIV_FIRST:
            begin
                if (cdiv_done)
                begin
                    lo_next    = CNT_W'(cdiv_quotient);
                    hi_next    = CNT_W'(cdiv_quotient) + CNT_W'(units_reg);
                    word_next  = WORD_W'(CNT_W'(cdiv_quotient) >> 3);
                    state_next = S_MARK_RD;
                end
            end

            S_MARK_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = word_reg;
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                // Modify and write back; count only bits that really change
                ram_we    = 1'b1;
                ram_waddr = word_reg;
                if (action_reg == ACT_ALLOC)
                begin
                    ram_wdata       = ram_rdata | mark_mask;
                    used_count_next = used_count_reg + CNT_W'(pop8(mark_mask));
                end
                else
                begin
                    ram_wdata       = ram_rdata & ~mark_mask;
                    used_count_next = used_count_reg - CNT_W'(pop8(ram_rdata & mark_mask));
                end
                if (word_reg == mark_last)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = (action_reg == ACT_ALLOC) ? alloc_addr : '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    word_next  = word_reg + WORD_W'(1);
                    state_next = S_MARK_RD;
                end
            end

            S_RESP:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    address_out_next = res_addr_reg;
                    block_empty_next = (used_count_reg == '0);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            word_reg       <= '0;
            used_count_reg <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        run_reg         <= run_next;
        start_reg       <= start_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        units_reg       <= units_next;
        action_reg      <= action_next;
        addr_in_reg     <= addr_in_next;
        res_status_reg  <= res_status_next;
        res_addr_reg    <= res_addr_next;
        status_reg      <= status_next;
        address_out_reg <= address_out_next;
        block_empty_reg <= block_empty_next;
    end

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign address_out = address_out_reg;
    assign block_empty = block_empty_reg;

    // Map never read and written at the same word in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("map read and write collide on one word");

    // Used count never exceeds the unit count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(NUM_UNITS))
        else $error("used count above unit count");

    // An accepted transaction closes the input
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input still open after accept");

    // Divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cdiv_done |-> (state_reg == S_DIV_UNITS || state_reg == S_DIV_FIRST))
        else $error("divider result with nobody waiting");

    // A pending result waits while the output register is held
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_valid_reg && out_stall) |=> (state_reg == S_RESP))
        else $error("result dropped under stall");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for bitmap_first_fit_unit_allocator: directed and random allocate/free traffic,
// checked against a behavioral copy of the used-unit map kept in this file.
// Depends on bffa_pkg and the allocator RTL only.
module tb_top;
    import bffa_pkg::*;

    localparam int UNIT_BYTES  = UNIT_BYTES_DEF;
    localparam int NUM_UNITS   = NUM_UNITS_DEF;
    localparam int SPAN_BYTES  = UNIT_BYTES * NUM_UNITS;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic                is_empty;
    } outcome_t;

    typedef struct {
        int first;
        int size;
    } region_t;

    // DUT connections
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                action = ACT_ALLOC;
    logic [SIZE_W-1:0]   size_bytes = '0;
    logic [ADDR_W-1:0]   address = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address_out;
    logic                block_empty;

    // Shadow of the allocator state
    bit                unit_busy [NUM_UNITS];
    int unsigned       busy_units = 0;
    logic [ADDR_W-1:0] base_shadow = '0;

    outcome_t pending_outcomes [$];
    region_t  live_regions [$];
    outcome_t head_outcome;
    int       mismatch_count = 0;
    int       quiet_cycles = 0;

    // Idle controls
    int in_gap_pct    = 18;
    int out_stall_pct = 59;
    bit hold_toggle   = 1'b0;
    bit hold_seen     = 1'b0;
    int hold_left     = 0;

    bitmap_first_fit_unit_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .size_bytes  (size_bytes),
        .address     (address),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .address_out (address_out),
        .block_empty (block_empty)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Compute the result of one transaction and update the shadow map
    function automatic outcome_t predict_outcome(input logic act,
                                                 input logic [SIZE_W-1:0] sz,
                                                 input logic [ADDR_W-1:0] addr);
        outcome_t          o;
        longint unsigned   units;
        longint unsigned   span;
        int                run;
        int                start;
        int                first;
        int                u;
        bit                found;
        o.status = ST_OK;
        o.addr   = '0;
        units = (64'(sz) + UNIT_BYTES - 1) / UNIT_BYTES;
        span  = 64'(SPAN_BYTES);
        if (sz == '0)
        begin
            o.status = ST_ZERO_SIZE;
        end
        else if (act == ACT_ALLOC)
        begin
            found = 1'b0;
            run   = 0;
            start = 0;
            // scan from unit 0 for the first free run that is long enough
            if (units <= NUM_UNITS)
            begin
                for (int k = 0; k < NUM_UNITS && !found; k++)
                begin
                    if (unit_busy[k])
                    begin
                        run   = 0;
                        start = k + 1;
                    end
                    else
                    begin
                        run++;
                        if (run >= units)
                            found = 1'b1;
                    end
                end
            end
            if (!found)
            begin
                o.status = ST_NO_SPACE;
            end
            else
            begin
                for (int k = 0; k < units; k++)
                    unit_busy[start + k] = 1'b1;
                busy_units += 32'(units);
                o.addr = base_shadow + ADDR_W'(start * UNIT_BYTES);
            end
        end
        else
        begin
            if (addr < base_shadow ||
                (64'(addr) - 64'(base_shadow)) + units * UNIT_BYTES > span)
            begin
                o.status = ST_OUT_BLOCK;
            end
            else
            begin
                // clear only units that are actually in use
                first = int'((addr - base_shadow) / UNIT_BYTES);
                for (int k = 0; k < units; k++)
                begin
                    u = first + k;
                    if (u < NUM_UNITS && unit_busy[u])
                    begin
                        unit_busy[u] = 1'b0;
                        if (busy_units > 0)
                            busy_units--;
                    end
                end
            end
        end
        o.is_empty = (busy_units == 0);
        return o;
    endfunction

    // Offer one transaction, wait for acceptance, queue its expected result
    task automatic send_item(input logic act, input logic [SIZE_W-1:0] sz,
                             input logic [ADDR_W-1:0] addr);
        outcome_t o;
        region_t  r;
        while ($urandom_range(99) < in_gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        size_bytes <= sz;
        address    <= addr;
        do
            @(posedge clk);
        while (in_stall);
        o = predict_outcome(act, sz, addr);
        pending_outcomes.push_back(o);
        if (act == ACT_ALLOC && o.status == ST_OK)
        begin
            r.first = int'((o.addr - base_shadow) / UNIT_BYTES);
            r.size  = int'(sz);
            live_regions.push_back(r);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write block_base while the allocator is idle
    task automatic write_base(input logic [ADDR_W-1:0] b);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        do
            @(posedge clk);
        while (!cfg_ready);
        base_shadow = b;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Release every unit and forget the tracked regions
    task automatic free_all();
        send_item(ACT_FREE, SIZE_W'(SPAN_BYTES), base_shadow);
        live_regions.delete();
    endtask

    function automatic logic [SIZE_W-1:0] rand_alloc_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return SIZE_W'($urandom_range(256, 1));
        else if (pick < 95)
            return SIZE_W'($urandom_range(4096, 257));
        else if (pick < 99)
            return SIZE_W'($urandom_range(32768, 4097));
        else
            return SIZE_W'($urandom_range(SPAN_BYTES, 32769));
    endfunction

    // Field extremes, first fit, partial and unaligned frees, range errors
    task automatic test_directed();
        logic [ADDR_W-1:0] b;
        write_base(32'h8000_0000);
        b = base_shadow;
        send_item(ACT_ALLOC, '0, $urandom);
        send_item(ACT_FREE, '0, b);
        send_item(ACT_ALLOC, 17'd1, '0);
        send_item(ACT_ALLOC, 17'd64, '1);
        send_item(ACT_ALLOC, 17'd65, $urandom);
        send_item(ACT_FREE, 17'd1, b + 32'd69);
        send_item(ACT_FREE, 17'd64, b + 32'd64);
        send_item(ACT_ALLOC, 17'd64, $urandom);
        send_item(ACT_ALLOC, 17'd128, $urandom);
        send_item(ACT_FREE, 17'd64, b - 32'd1);
        send_item(ACT_FREE, 17'd65, b + SPAN_BYTES - UNIT_BYTES);
        send_item(ACT_FREE, 17'd64, b + SPAN_BYTES - UNIT_BYTES);
        send_item(ACT_ALLOC, SIZE_W'(SPAN_BYTES), $urandom);
        send_item(ACT_ALLOC, SIZE_W'(SPAN_BYTES + 1), $urandom);
        send_item(ACT_ALLOC, '1, $urandom);
        send_item(ACT_FREE, '1, '1);
        free_all();
        send_item(ACT_ALLOC, SIZE_W'(SPAN_BYTES), $urandom);
        send_item(ACT_ALLOC, 17'd1, $urandom);
        free_all();
        send_item(ACT_ALLOC, 17'd4096, '1);
        send_item(ACT_FREE, 17'd4096, b);
        live_regions.delete();
    endtask

    // Base at the top of the address space: allocated addresses wrap
    task automatic test_base_wrap();
        write_base('1);
        send_item(ACT_ALLOC, 17'd1, $urandom);
        send_item(ACT_ALLOC, 17'd64, $urandom);
        send_item(ACT_FREE, 17'd64, 32'h0000_003F);
        send_item(ACT_FREE, 17'd128, '1);
        send_item(ACT_FREE, SIZE_W'(SPAN_BYTES + 1), '1);
        free_all();
        write_base('0);
        send_item(ACT_ALLOC, 17'd640, $urandom);
        send_item(ACT_FREE, 17'd64, '0);
        free_all();
    endtask

    // Mostly allocate/free pairs of live regions, plus noise
    task automatic test_random(input int count);
        int                kind;
        int                idx;
        region_t           r;
        logic [ADDR_W-1:0] a;
        logic              act;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            // lean toward frees when the map is filling up
            if (busy_units > 768 && live_regions.size() > 0 && kind < 45)
                kind = 60;
            if (kind < 45 || (kind < 80 && live_regions.size() == 0))
            begin
                send_item(ACT_ALLOC, rand_alloc_size(), $urandom);
            end
            else if (kind < 80)
            begin
                idx = $urandom_range(live_regions.size() - 1);
                r   = live_regions[idx];
                live_regions.delete(idx);
                a = base_shadow + ADDR_W'(r.first * UNIT_BYTES);
                if ($urandom_range(9) == 0)
                    a = a + $urandom_range(UNIT_BYTES - 1);
                send_item(ACT_FREE, SIZE_W'(r.size), a);
            end
            else
            begin
                act = 1'($urandom_range(1));
                case ($urandom_range(4))
                    0: send_item(act, '0, $urandom);
                    1: send_item(ACT_FREE, SIZE_W'($urandom_range(SPAN_BYTES)), $urandom);
                    2: send_item(ACT_FREE, SIZE_W'($urandom_range(8192, 1)),
                                 base_shadow + $urandom_range(SPAN_BYTES - 1));
                    3:
                    begin
                        if (base_shadow != '0)
                            a = $urandom_range(base_shadow - 1);
                        else
                            a = $urandom;
                        send_item(ACT_FREE, SIZE_W'($urandom_range(4096, 1)), a);
                    end
                    default: send_item(ACT_ALLOC, SIZE_W'($urandom_range(SPAN_BYTES, 1)),
                                       $urandom);
                endcase
            end
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming
    task automatic test_backpressure();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        @(posedge clk);
        hold_toggle = ~hold_toggle;
        test_random(60);
        wait_idle();
    endtask

    // Result-side stall: long hold on request, random otherwise
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d address 0x%08h empty %0b",
                         $time, status, address_out, block_empty);
                mismatch_count++;
            end
            else
            begin
                head_outcome = pending_outcomes.pop_front();
                if (status !== head_outcome.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_outcome.status, status);
                    mismatch_count++;
                end
                if (address_out !== head_outcome.addr)
                begin
                    $display("%0t: address_out expected 0x%08h actual 0x%08h",
                             $time, head_outcome.addr, address_out);
                    mismatch_count++;
                end
                if (block_empty !== head_outcome.is_empty)
                begin
                    $display("%0t: block_empty expected %0b actual %0b",
                             $time, head_outcome.is_empty, block_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a run that has gone quiet for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_base_wrap();

        write_base('0);
        test_random(430);

        in_gap_pct    = 59;
        out_stall_pct = 18;
        write_base($urandom_range(32'hFFFF_0000));
        test_random(430);

        in_gap_pct    = 0;
        out_stall_pct = 0;
        write_base(32'hFFFF_0000);
        test_random(400);

        test_backpressure();

        wait_idle();
        repeat (600) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
